// ----- sv/ccp_pkg.sv -----
// shared types and constants for the chunk container parser
package ccp_pkg;

    localparam logic [31:0] MAGIC_RESET = 32'h5453_4247;

    typedef enum logic [1:0] {
        PH_FILE_HDR = 2'd0,
        PH_SEC_HDR  = 2'd1,
        PH_SEC_DATA = 2'd2,
        PH_IGNORE   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        K_HEADER  = 3'd0,
        K_VERSION = 3'd1,
        K_OPEN    = 3'd2,
        K_DATA    = 3'd3,
        K_IGNORED = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_SHORT = 2'd1,
        ERR_MAGIC = 2'd2,
        ERR_TRUNC = 2'd3
    } t_err;

    localparam logic [2:0] CNT_MAGIC_END = 3'd4;
    localparam logic [2:0] CNT_LEN_LAST  = 3'd7;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  hdr_cnt;
        logic        mismatch;
        logic [7:0]  ver_lo;
        logic [31:0] name;
        logic [31:0] len;
        logic [31:0] remaining;
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] version;
        logic [31:0] section_name;
        logic [31:0] section_length;
        logic [7:0]  payload_byte;
        logic        last_of_section;
        logic        file_done;
        t_err        error_code;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:     PH_FILE_HDR,
        hdr_cnt:   3'd0,
        mismatch:  1'b0,
        ver_lo:    8'd0,
        name:      32'd0,
        len:       32'd0,
        remaining: 32'd0
    };

endpackage

// ----- sv/ccp_step.sv -----
// one parse step: next parser state and the result for one byte
module ccp_step
    import ccp_pkg::*;
(
    input  t_state      i_state,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    input  logic [31:0] i_magic,
    output t_state      o_state,
    output t_result     o_result
);

    logic [2:0]  cnt;
    logic [31:0] len_full;
    logic [7:0]  magic_byte;

    assign cnt        = i_state.hdr_cnt;
    assign len_full   = {i_data_byte, i_state.len[31:8]};
    assign magic_byte = i_magic[{cnt[1:0], 3'b000} +: 8];

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.kind       = K_HEADER;
        o_result.error_code = ERR_OK;
        case (i_state.phase)
            PH_SEC_HDR: begin
                if (cnt < CNT_MAGIC_END) begin
                    o_state.name    = {i_data_byte, i_state.name[31:8]};
                    o_state.hdr_cnt = cnt + 3'd1;
                end else if (cnt < CNT_LEN_LAST) begin
                    o_state.len     = len_full;
                    o_state.hdr_cnt = cnt + 3'd1;
                end else begin
                    o_state.len             = len_full;
                    o_state.hdr_cnt         = 3'd0;
                    o_result.kind           = K_OPEN;
                    o_result.section_name   = i_state.name;
                    o_result.section_length = len_full;
                    if (len_full == 32'd0) begin
                        o_result.last_of_section = 1'b1;
                    end else begin
                        o_state.remaining = len_full;
                        o_state.phase     = PH_SEC_DATA;
                        if (i_is_last) begin
                            o_result.error_code = ERR_TRUNC;
                        end
                    end
                end
            end
            PH_SEC_DATA: begin
                o_result.kind         = K_DATA;
                o_result.payload_byte = i_data_byte;
                if (i_state.remaining <= 32'd1) begin
                    o_state.remaining        = 32'd0;
                    o_state.phase            = PH_SEC_HDR;
                    o_state.hdr_cnt          = 3'd0;
                    o_result.last_of_section = 1'b1;
                end else begin
                    o_state.remaining = i_state.remaining - 32'd1;
                    if (i_is_last) begin
                        o_result.error_code = ERR_TRUNC;
                    end
                end
            end
            PH_IGNORE: begin
                o_result.kind = K_IGNORED;
                if (i_is_last) begin
                    o_result.error_code = ERR_MAGIC;
                end
            end
            default: begin
                if (cnt < CNT_MAGIC_END) begin
                    if (i_data_byte != magic_byte) begin
                        o_state.mismatch = 1'b1;
                    end
                    o_state.hdr_cnt = cnt + 3'd1;
                    if (i_is_last) begin
                        o_result.error_code = ERR_SHORT;
                    end
                end else if (cnt == CNT_MAGIC_END) begin
                    o_state.ver_lo  = i_data_byte;
                    o_state.hdr_cnt = 3'd5;
                    if (i_is_last) begin
                        o_result.error_code = ERR_SHORT;
                    end
                end else begin
                    o_state.hdr_cnt = 3'd0;
                    if (i_state.mismatch) begin
                        o_result.kind = K_IGNORED;
                        o_state.phase = PH_IGNORE;
                        if (i_is_last) begin
                            o_result.error_code = ERR_MAGIC;
                        end
                    end else begin
                        o_result.kind    = K_VERSION;
                        o_result.version = {i_data_byte, i_state.ver_lo};
                        o_state.phase    = PH_SEC_HDR;
                    end
                end
            end
        endcase
        o_result.file_done = i_is_last;
        if (!i_is_last) begin
            o_result.error_code = ERR_OK;
        end else begin
            o_state = STATE_RESET;
        end
    end

endmodule

// ----- sv/chunk_container_parser_top.sv -----
// chunk container parser top level: input word register, parse step, result register
// a word accepted into the input register goes through the parse step into the result register once that is free
// throughput: one word per cycle while the output is not stalled; the step logic updates the state for each word
// an input register lets a word enter while a finished result still waits at the output
// reset (synchronous, active low) empties both stages, returns the parser to the file header
// and loads the magic register with its default; no clearing pass is needed
module chunk_container_parser_top
    import ccp_pkg::*;
#(
    parameter logic [31:0] MAGIC_DEFAULT = MAGIC_RESET
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_result_kind,
    output logic [15:0] o_version,
    output logic [31:0] o_section_name,
    output logic [31:0] o_section_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_of_section,
    output logic        o_file_done,
    output logic [1:0]  o_error_code
);

    logic [31:0] r_magic;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_state      r_st;
    t_state      n_st;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    ccp_step u_step (
        .i_state     (r_st),
        .i_data_byte (r_in_byte),
        .i_is_last   (r_in_last),
        .i_magic     (r_magic),
        .o_state     (n_st),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_DEFAULT;
        end else if (i_cfg_we) begin
            r_magic <= i_cfg_wdata;
        end
    end

    // input word stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_is_last;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_RESET;
        end else if (advance) begin
            r_st <= n_st;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_out.kind;
    assign o_version         = r_out.version;
    assign o_section_name    = r_out.section_name;
    assign o_section_length  = r_out.section_length;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_last_of_section = r_out.last_of_section;
    assign o_file_done       = r_out.file_done;
    assign o_error_code      = r_out.error_code;

    a_err_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_file_done |-> o_error_code == ERR_OK)
        else $error("error code without end of file");

    a_los_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_section |-> o_result_kind == K_OPEN
            || o_result_kind == K_DATA)
        else $error("last of section on wrong kind");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_st.phase == PH_FILE_HDR && r_st.hdr_cnt == 3'd0
            && !r_st.mismatch)
        else $error("parser not restarted after final word");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !advance)
        else $error("waiting result overwritten");

endmodule

// ----- tb/chunk_container_parser_checker.sv -----
// checker for the chunk container parser: predicts every result word and compares it
module chunk_container_parser_checker
    import ccp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_result_kind,
    input  logic [15:0] i_version,
    input  logic [31:0] i_section_name,
    input  logic [31:0] i_section_length,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_of_section,
    input  logic        i_file_done,
    input  logic [1:0]  i_error_code,
    output int          o_pending,
    output int          o_fail_count
);

    logic [31:0] magic_q;
    t_phase      phase;
    logic [2:0]  hdr_cnt;
    logic        mismatch;
    logic [7:0]  ver_lo;
    logic [31:0] name_sr;
    logic [31:0] len_sr;
    logic [31:0] remaining;
    t_result     expected_q[$];

    function automatic void clear_parse();
        phase     = PH_FILE_HDR;
        hdr_cnt   = '0;
        mismatch  = 1'b0;
        ver_lo    = '0;
        name_sr   = '0;
        len_sr    = '0;
        remaining = '0;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b, input logic last);
        t_result    r;
        t_err       err;
        logic [2:0] cnt;
        r   = '0;
        err = ERR_OK;
        cnt = hdr_cnt;
        case (phase)
            PH_SEC_HDR: begin
                if (cnt < CNT_MAGIC_END) begin
                    name_sr = {b, name_sr[31:8]};
                    hdr_cnt = cnt + 3'd1;
                end else begin
                    len_sr = {b, len_sr[31:8]};
                    if (cnt < CNT_LEN_LAST) begin
                        hdr_cnt = cnt + 3'd1;
                    end else begin
                        r.kind           = K_OPEN;
                        r.section_name   = name_sr;
                        r.section_length = len_sr;
                        hdr_cnt          = '0;
                        if (len_sr == '0) begin
                            r.last_of_section = 1'b1;
                        end else begin
                            remaining = len_sr;
                            phase     = PH_SEC_DATA;
                            if (last) err = ERR_TRUNC;
                        end
                    end
                end
            end
            PH_SEC_DATA: begin
                r.kind         = K_DATA;
                r.payload_byte = b;
                if (remaining <= 32'd1) begin
                    remaining         = '0;
                    r.last_of_section = 1'b1;
                    phase             = PH_SEC_HDR;
                    hdr_cnt           = '0;
                end else begin
                    remaining = remaining - 32'd1;
                    if (last) err = ERR_TRUNC;
                end
            end
            PH_IGNORE: begin
                r.kind = K_IGNORED;
                if (last) err = ERR_MAGIC;
            end
            default: begin
                if (cnt < CNT_MAGIC_END) begin
                    if (b != magic_q[8*cnt +: 8]) mismatch = 1'b1;
                    hdr_cnt = cnt + 3'd1;
                    if (last) err = ERR_SHORT;
                end else if (cnt == CNT_MAGIC_END) begin
                    ver_lo  = b;
                    hdr_cnt = cnt + 3'd1;
                    if (last) err = ERR_SHORT;
                end else begin
                    hdr_cnt = '0;
                    if (mismatch) begin
                        r.kind = K_IGNORED;
                        phase  = PH_IGNORE;
                        if (last) err = ERR_MAGIC;
                    end else begin
                        r.kind    = K_VERSION;
                        r.version = {b, ver_lo};
                        phase     = PH_SEC_HDR;
                    end
                end
            end
        endcase
        r.file_done  = last;
        r.error_code = last ? err : ERR_OK;
        if (last) clear_parse();
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: chunk parser mismatch: %s", $time, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            magic_q = MAGIC_RESET;
            clear_parse();
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) magic_q = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    check_field("result_kind", 32'(i_result_kind), 32'(want.kind));
                    check_field("version", 32'(i_version), 32'(want.version));
                    check_field("section_name", i_section_name, want.section_name);
                    check_field("section_length", i_section_length, want.section_length);
                    check_field("payload_byte", 32'(i_payload_byte),
                                32'(want.payload_byte));
                    check_field("last_of_section", 32'(i_last_of_section),
                                32'(want.last_of_section));
                    check_field("file_done", 32'(i_file_done), 32'(want.file_done));
                    check_field("error_code", 32'(i_error_code), 32'(want.error_code));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_q = {expected_q, parse_byte(i_data_byte, i_is_last)};
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- tb/chunk_container_parser_top_tb.sv -----
// testbench top for the chunk container parser: file stimulus, stall patterns and verdict
module chunk_container_parser_top_tb
    import ccp_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  result_kind;
    logic [15:0] version;
    logic [31:0] section_name;
    logic [31:0] section_length;
    logic [7:0]  payload_byte;
    logic        last_of_section;
    logic        file_done;
    logic [1:0]  error_code;
    int          pending;
    int          fail_count;

    logic [31:0] magic_now = MAGIC_RESET;
    logic [7:0]  file_q[$];
    int          words_sent = 0;
    bit          quiet = 1'b0;

    always #5 clk = ~clk;

    chunk_container_parser_top u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_data_byte       (data_byte),
        .i_is_last         (is_last),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_result_kind     (result_kind),
        .o_version         (version),
        .o_section_name    (section_name),
        .o_section_length  (section_length),
        .o_payload_byte    (payload_byte),
        .o_last_of_section (last_of_section),
        .o_file_done       (file_done),
        .o_error_code      (error_code)
    );

    chunk_container_parser_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_data_byte       (data_byte),
        .i_is_last         (is_last),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_result_kind     (result_kind),
        .i_version         (version),
        .i_section_name    (section_name),
        .i_section_length  (section_length),
        .i_payload_byte    (payload_byte),
        .i_last_of_section (last_of_section),
        .i_file_done       (file_done),
        .i_error_code      (error_code),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic add_byte(input logic [7:0] b);
        file_q = {file_q, b};
    endtask

    task automatic send_word(input logic [7:0] b, input logic last, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        is_last   <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        magic_now = value;
    endtask

    task automatic send_file(input int pause_at);
        foreach (file_q[i]) begin
            if (i == pause_at) wait_drained();
            send_word(file_q[i], i == file_q.size() - 1, quiet ? 0 : pick_gap());
        end
        words_sent += file_q.size();
    endtask

    task automatic make_file();
        int          style;
        int          hdr_len;
        int          bad;
        int          nsec;
        int          n;
        logic [31:0] len;
        logic [7:0]  hdr[6];
        file_q.delete();
        style = $urandom_range(0, 19);
        // pure noise
        if (style == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) add_byte(8'($urandom));
            return;
        end
        bad     = (style <= 2) ? $urandom_range(0, 4) : 4;
        hdr_len = (style == 1) ? $urandom_range(1, 5) : 6;
        for (int i = 0; i < 4; i++) begin
            hdr[i] = magic_now[8*i +: 8];
            if (i == bad) hdr[i] = hdr[i] ^ 8'($urandom_range(1, 255));
        end
        hdr[4] = 8'($urandom);
        hdr[5] = 8'($urandom);
        for (int i = 0; i < hdr_len; i++) add_byte(hdr[i]);
        if (style == 1) return;
        nsec = $urandom_range(0, 3);
        for (int s = 0; s < nsec; s++) begin
            repeat (4) add_byte(8'($urandom));
            n = $urandom_range(0, 9);
            if (n < 2) len = '0;
            else if (n < 8) len = $urandom_range(1, 10);
            else len = $urandom;
            for (int i = 0; i < 4; i++) add_byte(len[8*i +: 8]);
            // file ends within this section, mostly before its last byte
            if (len > 32'd16 || $urandom_range(0, 11) == 0) begin
                n = (len > 32'd16) ? $urandom_range(0, 4) : $urandom_range(0, len);
                repeat (n) add_byte(8'($urandom));
                return;
            end
            repeat (len) add_byte(8'($urandom));
        end
        // trailing partial section header
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 7);
            repeat (n) add_byte(8'($urandom));
        end
    endtask

    initial begin : rx_stall
        int burst;
        int stall;
        forever begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (burst) @(posedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("chunk_container_parser_top_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int          target;
        logic [31:0] next_magic;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // one-byte file: short header wins over bad magic
        file_q.delete();
        add_byte(8'hFF);
        send_file(-1);

        // good header, version 0xff00, empty section, partial trailing header
        file_q.delete();
        for (int i = 0; i < 4; i++) add_byte(magic_now[8*i +: 8]);
        add_byte(8'h00);
        add_byte(8'hFF);
        repeat (4) add_byte(8'hFF);
        repeat (4) add_byte(8'h00);
        add_byte(8'h5A);
        add_byte(8'hA5);
        add_byte(8'h3C);
        send_file(9);

        // bad magic, then one ignored word
        file_q.delete();
        for (int i = 0; i < 4; i++) add_byte(magic_now[8*i +: 8]);
        file_q[0] = file_q[0] ^ 8'h01;
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h77);
        send_file(-1);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       next_magic = '0;
                1:       next_magic = '1;
                2:       next_magic = $urandom;
                default: next_magic = MAGIC_RESET;
            endcase
            write_magic(next_magic);
            target = words_sent + 100;
            while (words_sent < target) begin
                make_file();
                quiet = ($urandom_range(0, 5) == 0);
                send_file(($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, file_q.size() - 1) : -1);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("chunk_container_parser_top_tb: PASS");
        end else begin
            $display("chunk_container_parser_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/ccp_pkg.sv
sv/ccp_step.sv
sv/chunk_container_parser_top.sv
tb/chunk_container_parser_checker.sv
tb/chunk_container_parser_top_tb.sv
